### rtl/block_rms_gate_smoother_assert.svh
// ----------------------------------------------------------------------------
// block_rms_gate_smoother assertion macros
// shared property forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BLOCK_RMS_GATE_SMOOTHER_ASSERT_SVH
`define BLOCK_RMS_GATE_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define RMSGS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmsgs assertion failed");

// next-cycle implication
`define RMSGS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmsgs assertion failed");

`endif

### rtl/rmsgs_pkg.sv
// ----------------------------------------------------------------------------
// rmsgs_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package rmsgs_pkg;

	localparam int CH_W      = 3;
	localparam int CHANNELS  = 8;
	localparam int MAX_BLOCK = 4096;
	localparam int CNT_W     = 13;
	localparam int LEVEL_W   = 17;
	localparam int REG_W     = 16;
	localparam int IDX_W     = 2;
	localparam int STEP_W    = 6;
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;

	// register indexes
	localparam logic [IDX_W-1:0] REG_GAIN      = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [IDX_W-1:0] REG_SMOOTHING = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic mul1;
		logic mul2;
		logic acc;
		logic div_init;
		logic div_step;
		logic sqrt_step;
		logic mix1;
		logic mix2;
		logic emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last;
		logic out_busy;
	} sts_t;

endpackage

### rtl/rmsgs_ctrl.sv
// ----------------------------------------------------------------------------
// rmsgs_ctrl
// sequencer for per-sample accumulate and end-of-block level computation
// ----------------------------------------------------------------------------
module rmsgs_ctrl import rmsgs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_MUL1  = 11'b000_0000_0010,
		S_MUL2  = 11'b000_0000_0100,
		S_ACC   = 11'b000_0000_1000,
		S_DINIT = 11'b000_0001_0000,
		S_DIV   = 11'b000_0010_0000,
		S_SQRT  = 11'b000_0100_0000,
		S_MIX1  = 11'b000_1000_0000,
		S_MIX2  = 11'b001_0000_0000,
		S_EMIT  = 11'b010_0000_0000,
		S_SPARE = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	assign sample_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? S_DINIT : S_IDLE;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				step_d       = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					step_d  = '0;
					state_d = S_SQRT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					step_d  = '0;
					state_d = S_MIX1;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_MIX1: begin
				cmd.mix1 = 1'b1;
				state_d  = S_MIX2;
			end
			S_MIX2: begin
				cmd.mix2 = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

`include "block_rms_gate_smoother_assert.svh"

	`RMSGS_ASSERT_NEXT(a_accept_starts, (state_q == S_IDLE) && sample_valid, state_q == S_MUL1)
	`RMSGS_ASSERT_NEXT(a_plain_sample_done, (state_q == S_ACC) && !sts.last, state_q == S_IDLE)
	`RMSGS_ASSERT_NEXT(a_div_to_sqrt, (state_q == S_DIV) && (step_q == STEP_W'(DIV_STEPS - 1)), (state_q == S_SQRT) && (step_q == '0))
	`RMSGS_ASSERT_SAME(a_emit_when_free, cmd.emit, !sts.out_busy)

endmodule

### rtl/rmsgs_dp.sv
// ----------------------------------------------------------------------------
// rmsgs_dp
// per-channel state, multipliers, serial divider and square root, smoother
// ----------------------------------------------------------------------------
module rmsgs_dp import rmsgs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [REG_W-1:0]    wr_data,
	input  logic [CH_W-1:0]     channel,
	input  logic signed [23:0]  sample,
	input  logic                last,
	output logic                level_valid,
	input  logic                level_stall,
	output logic [CH_W-1:0]     out_channel,
	output logic [LEVEL_W-1:0]  level,
	input  cmd_t                cmd,
	output sts_t                sts
);

	logic [REG_W-1:0] gain_q, thr_q, smooth_q;

	logic [CH_W-1:0]    ch_q;
	logic [23:0]        mag_q;
	logic               last_q;
	logic [24:0]        m_s1;
	logic [49:0]        sq_s2;

	logic [63:0]        sum_q [CHANNELS];
	logic [CNT_W-1:0]   cnt_q [CHANNELS];
	logic [LEVEL_W-1:0] lvl_mem_q [CHANNELS];

	logic [63:0]        quo_q;
	logic [CNT_W-1:0]   drem_q;
	logic [CNT_W-1:0]   divisor_q;
	logic [33:0]        srem_q;
	logic [31:0]        root_q;
	logic [25:0]        rms_q;
	logic [32:0]        p1_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic               out_valid_q;
	logic [CH_W-1:0]    out_ch_q;
	logic [LEVEL_W-1:0] out_lvl_q;

	logic [23:0]  sample_u, mag_d;
	logic [39:0]  prod1;
	logic [64:0]  sum_ext;
	logic [63:0]  sum_sat;
	logic [CNT_W:0] rem2;
	logic [34:0]  srem2;
	logic [34:0]  trial;
	logic [32:0]  r_round;
	logic [25:0]  rms_d;
	logic [16:0]  one_minus;
	logic [42:0]  prod2;
	logic [43:0]  mix_acc;
	logic [LEVEL_W-1:0] lvl_d;

	// magnitude of the two's complement sample
	assign sample_u = sample;
	assign mag_d    = sample[23] ? (~sample_u + 24'd1) : sample_u;

	assign prod1   = mag_q * gain_q + 40'd8192;
	assign sum_ext = {1'b0, sum_q[ch_q]} + {15'd0, sq_s2};
	assign sum_sat = sum_ext[64] ? '1 : sum_ext[63:0];

	// restoring divider, one quotient bit per step
	assign rem2 = {drem_q, quo_q[63]};

	// digit-by-digit square root, two radicand bits per step
	assign srem2 = {srem_q[32:0], quo_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	assign r_round = {1'b0, root_q} + 33'd64;
	assign rms_d   = (r_round[32:7] < {10'd0, thr_q}) ? '0 : r_round[32:7];

	assign one_minus = 17'h10000 - {1'b0, smooth_q};
	assign prod2     = rms_q * one_minus;
	assign mix_acc   = {11'd0, p1_q} + {1'b0, prod2} + 44'd32768;
	assign lvl_d     = (mix_acc[43:16] > {11'd0, LEVEL_MAX}) ? LEVEL_MAX
	                   : mix_acc[32:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 16'd16384;
			thr_q    <= 16'd655;
			smooth_q <= 16'd6554;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIN:      gain_q   <= wr_data;
				REG_THRESHOLD: thr_q    <= wr_data;
				REG_SMOOTHING: smooth_q <= wr_data;
				default: ;
			endcase
		end
	end

	// per-channel state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]     <= '0;
				cnt_q[i]     <= '0;
				lvl_mem_q[i] <= '0;
			end
		end else begin
			if (cmd.acc && (cnt_q[ch_q] < CNT_W'(MAX_BLOCK))) begin
				sum_q[ch_q] <= sum_sat;
				cnt_q[ch_q] <= cnt_q[ch_q] + 1'b1;
			end
			if (cmd.mix2) begin
				lvl_mem_q[ch_q] <= lvl_d;
				sum_q[ch_q]     <= '0;
				cnt_q[ch_q]     <= '0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q   <= channel;
			mag_q  <= mag_d;
			last_q <= last;
		end
		if (cmd.mul1) m_s1  <= prod1[38:14];
		if (cmd.mul2) sq_s2 <= m_s1 * m_s1;
		if (cmd.div_init) begin
			// empty count reads as a zero mean
			quo_q     <= (cnt_q[ch_q] == '0) ? '0 : sum_q[ch_q];
			divisor_q <= (cnt_q[ch_q] == '0) ? CNT_W'(1) : cnt_q[ch_q];
			drem_q    <= '0;
			srem_q    <= '0;
			root_q    <= '0;
		end
		if (cmd.div_step) begin
			if (rem2 >= {1'b0, divisor_q}) begin
				drem_q <= CNT_W'(rem2 - {1'b0, divisor_q});
				quo_q  <= {quo_q[62:0], 1'b1};
			end else begin
				drem_q <= rem2[CNT_W-1:0];
				quo_q  <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.sqrt_step) begin
			quo_q <= {quo_q[61:0], 2'b00};
			if (srem2 >= trial) begin
				srem_q <= 34'(srem2 - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= srem2[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.mix1) begin
			rms_q <= rms_d;
			p1_q  <= lvl_mem_q[ch_q] * smooth_q;
		end
		if (cmd.mix2) lvl_q <= lvl_d;
		if (cmd.emit) begin
			out_ch_q  <= ch_q;
			out_lvl_q <= lvl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!level_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign level_valid  = out_valid_q;
	assign out_channel  = out_ch_q;
	assign level        = out_lvl_q;
	assign sts.last     = last_q;
	assign sts.out_busy = out_valid_q & level_stall;

endmodule

### rtl/block_rms_gate_smoother.sv
// ----------------------------------------------------------------------------
// block_rms_gate_smoother
// per-channel block rms detector with noise gate and one-pole smoothing
// ----------------------------------------------------------------------------
// One sample at a time: after the transfer, every sample passes through the
// scale multiply, the square and the saturating accumulate in turn. A
// sample with the last flag goes on: it loads the divider, forms the mean
// by a restoring divider at one bit per cycle, the root by a digit-serial
// square root at one bit per cycle, runs the smoother and moves the level
// into the output register. The finished level sits in that register, so a
// new sample is taken while the result waits; only a second finished block
// stalls until the first result transfers. Per-channel sums, counts and
// levels are cleared by reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_rms_gate_smoother import rmsgs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes: gain, threshold, smoothing
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [REG_W-1:0]    wr_data,
	// sample channel
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [CH_W-1:0]     channel,
	input  logic signed [23:0]  sample,
	input  logic                last,
	// level channel
	output logic                level_valid,
	input  logic                level_stall,
	output logic [CH_W-1:0]     out_channel,
	output logic [LEVEL_W-1:0]  level
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: one state per arithmetic step, step counter for serial units
	rmsgs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// arithmetic, channel state and output register
	rmsgs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.channel     (channel),
		.sample      (sample),
		.last        (last),
		.level_valid (level_valid),
		.level_stall (level_stall),
		.out_channel (out_channel),
		.level       (level),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

### dv/block_rms_gate_smoother_checker.sv
// ----------------------------------------------------------------------------
// block_rms_gate_smoother_checker
// watches config writes and both channels, predicts each channel's smoothed
// level and compares every level transfer with the oldest prediction
// ----------------------------------------------------------------------------
module block_rms_gate_smoother_checker import rmsgs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_index,
	input  logic [REG_W-1:0]    wr_data,
	input  logic                sample_valid,
	input  logic                sample_stall,
	input  logic [CH_W-1:0]     channel,
	input  logic signed [23:0]  sample,
	input  logic                last,
	input  logic                level_valid,
	input  logic                level_stall,
	input  logic [CH_W-1:0]     out_channel,
	input  logic [LEVEL_W-1:0]  level,
	output int                  fail_count,
	output int                  pending
);
	typedef struct {
		logic [CH_W-1:0]    ch;
		logic [LEVEL_W-1:0] lvl;
	} level_t;

	level_t pending_levels[$];
	logic [15:0] gain_q, thresh_q, smooth_q;
	logic [63:0] sq_sum[CHANNELS];
	int unsigned blk_cnt[CHANNELS];
	logic [LEVEL_W-1:0] smooth_lvl[CHANNELS];

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	task automatic predict_sample(logic [CH_W-1:0] ch, logic signed [23:0] s, logic lst);
		logic [63:0] mag, m, sq, mean, rms, acc;
		level_t e;
		if (blk_cnt[ch] < MAX_BLOCK) begin
			mag = s[23] ? 64'(25'h1000000 - {1'b0, s}) : 64'(s);
			m = (mag * gain_q + 64'd8192) >> 14;
			sq = m * m;
			if (sq_sum[ch] > ~64'd0 - sq) sq_sum[ch] = ~64'd0;
			else sq_sum[ch] = sq_sum[ch] + sq;
			blk_cnt[ch]++;
		end
		if (!lst) return;
		mean = blk_cnt[ch] != 0 ? sq_sum[ch] / 64'(blk_cnt[ch]) : 64'd0;
		rms = (int_sqrt(mean) + 64'd64) >> 7;
		if (rms < 64'(thresh_q)) rms = 0;
		acc = 64'(smooth_lvl[ch]) * smooth_q + rms * (64'd65536 - smooth_q) + 64'd32768;
		acc >>= 16;
		if (acc > 64'(LEVEL_MAX)) acc = 64'(LEVEL_MAX);
		smooth_lvl[ch] = acc[LEVEL_W-1:0];
		sq_sum[ch] = 0;
		blk_cnt[ch] = 0;
		e.ch = ch;
		e.lvl = acc[LEVEL_W-1:0];
		pending_levels.push_back(e);
	endtask

	assign pending = pending_levels.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd16384;
			thresh_q <= 16'd655;
			smooth_q <= 16'd6554;
			for (int c = 0; c < CHANNELS; c++) begin
				sq_sum[c] = 0;
				blk_cnt[c] = 0;
				smooth_lvl[c] = 0;
			end
			pending_levels.delete();
			fail_count <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_GAIN:      gain_q <= wr_data;
					REG_THRESHOLD: thresh_q <= wr_data;
					REG_SMOOTHING: smooth_q <= wr_data;
					default: ;
				endcase
			end
			if (level_valid && !level_stall) begin
				if (pending_levels.size() == 0) begin
					$display("%0t unexpected level: expected none, actual ch %0d level %0d",
						$time, out_channel, level);
					fail_count <= fail_count + 1;
				end else begin
					level_t e;
					e = pending_levels.pop_front();
					if (e.ch !== out_channel || e.lvl !== level) begin
						$display("%0t mismatch: expected ch %0d level %0d, actual ch %0d level %0d",
							$time, e.ch, e.lvl, out_channel, level);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (sample_valid && !sample_stall)
				predict_sample(channel, sample, last);
		end
	end
endmodule

### dv/block_rms_gate_smoother_test.sv
// ----------------------------------------------------------------------------
// block_rms_gate_smoother_test
// directed and random sample streams over several register settings, with
// random idling on both sides and a long receiver hold-off
// ----------------------------------------------------------------------------
module block_rms_gate_smoother_test;
	import rmsgs_pkg::*;

	logic clk, arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [REG_W-1:0] wr_data;
	logic sample_valid, sample_stall;
	logic [CH_W-1:0] channel;
	logic signed [23:0] sample;
	logic last;
	logic level_valid, level_stall;
	logic [CH_W-1:0] out_channel;
	logic [LEVEL_W-1:0] level;
	int fail_count, pending;

	// receiver control
	bit calm;              // no idling at all
	bit hold_req;          // stimulus asks for one long hold-off
	bit hold_taken;        // hold-off has started
	int hold_left;         // cycles of forced stall still to go
	int idle_cycles = 0;   // watchdog: cycles without any transfer

	localparam int BLOCK_LAT = 120;
	localparam int HOLD_LEN = 1500;
	localparam int WATCHDOG = 20000;

	block_rms_gate_smoother dut (.*);

	block_rms_gate_smoother_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver: random stall, with a counted long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_stall <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			level_stall <= 1'b1;
			hold_left <= HOLD_LEN - 1;
			hold_taken <= 1'b1;
		end else if (hold_left > 0) begin
			level_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			level_stall <= !calm && ($urandom_range(99) < 32);
		end
	end

	// watchdog on transfers of either channel
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (level_valid && !level_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL block_rms_gate_smoother");
			$finish;
		end
	end

	// one sample transfer; valid stays high between back-to-back items
	task automatic send(logic [CH_W-1:0] ch, logic signed [23:0] s, logic lst);
		while (!calm && $urandom_range(99) < 32) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		channel <= ch;
		sample <= s;
		last <= lst;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (BLOCK_LAT) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(255)) - 24'sd128;
			default: return 24'($urandom);
		endcase
	endfunction

	// random blocks of random length, mostly short, a few long ones
	task automatic random_blocks(int n_items);
		int sent, len;
		logic [CH_W-1:0] ch;
		sent = 0;
		while (sent < n_items) begin
			ch = CH_W'($urandom_range(CHANNELS - 1));
			len = ($urandom_range(19) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				// occasional interleaved sample on a random channel
				if ($urandom_range(9) == 0)
					send(CH_W'($urandom), rand_sample(), 1'b0);
				send(ch, rand_sample(), i == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 0;
		calm = 0;
		hold_req = 0;
		wr_en = 0;
		wr_index = REG_GAIN;
		wr_data = 0;
		sample_valid = 0;
		channel = 0;
		sample = 0;
		last = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes with reset settings
		send(3'd0, 24'sh7FFFFF, 1'b1);
		send(3'd1, 24'sh800000, 1'b1);
		send(3'd2, 24'sd0, 1'b1);
		send(3'd7, 24'sh7FFFFF, 1'b0);
		send(3'd7, 24'sh800000, 1'b0);
		send(3'd7, 24'sd1, 1'b1);
		send(3'd3, 24'sd100, 1'b1);
		drain();

		// full gain, no smoothing, gate off
		write_reg(REG_GAIN, 16'hFFFF);
		write_reg(REG_THRESHOLD, 16'd0);
		write_reg(REG_SMOOTHING, 16'd0);
		write_reg(2'd3, 16'h1234);
		send(3'd4, 24'sh7FFFFF, 1'b0);
		send(3'd4, 24'sh800000, 1'b1);
		send(3'd5, 24'sd1, 1'b1);
		drain();

		// gate everything, full smoothing
		write_reg(REG_THRESHOLD, 16'hFFFF);
		write_reg(REG_SMOOTHING, 16'hFFFF);
		write_reg(REG_GAIN, 16'd0);
		send(3'd0, 24'sh7FFFFF, 1'b1);
		send(3'd1, 24'sh123456, 1'b1);
		drain();

		// pressure: receiver holds off while the sender keeps going
		write_reg(REG_GAIN, 16'd32768);
		write_reg(REG_THRESHOLD, 16'd655);
		write_reg(REG_SMOOTHING, 16'd6554);
		hold_req <= 1'b1;
		for (int i = 0; i < 12; i++)
			send(CH_W'(i), rand_sample(), 1'b1);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_GAIN, ph == 0 ? 16'd32768 : 16'($urandom));
			write_reg(REG_THRESHOLD, ph == 1 ? 16'd0 : 16'($urandom_range(2000)));
			write_reg(REG_SMOOTHING, ph == 2 ? 16'hFFFF : 16'($urandom));
			calm = (ph == 3);
			random_blocks(ph == 3 ? 350 : 450);
			calm = 0;
			drain();
		end

		if (fail_count == 0)
			$display("PASS block_rms_gate_smoother");
		else
			$display("FAIL block_rms_gate_smoother");
		$finish;
	end
endmodule
